[rtl/core/bezier_point_eval_unit_assert.svh]
// assertion macros for the bezier point evaluator
`ifndef BEZIER_POINT_EVAL_UNIT_ASSERT_SVH
`define BEZIER_POINT_EVAL_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BPE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define BPE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/bpe_pkg.sv]
// shared constants, control word and microcode rom of the bezier point evaluator
package bpe_pkg;

    localparam int MAX_POINTS = 16;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 24;
    localparam int T_W        = 17;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = DIFF_W + T_W + 1;
    localparam int FRAC_T     = 16;
    localparam int STEP_W     = 3;

    localparam logic [T_W-1:0]    T_ONE    = T_W'(65536);
    localparam logic [PROD_W-1:0] T_HALF   = PROD_W'(32768);

    // microprogram addresses
    localparam logic [STEP_W-1:0] S_IDLE  = 3'd0;
    localparam logic [STEP_W-1:0] S_START = 3'd1;
    localparam logic [STEP_W-1:0] S_LD0   = 3'd2;
    localparam logic [STEP_W-1:0] S_RDQ   = 3'd3;
    localparam logic [STEP_W-1:0] S_MUL   = 3'd4;
    localparam logic [STEP_W-1:0] S_ADD   = 3'd5;
    localparam logic [STEP_W-1:0] S_OUT   = 3'd6;
    localparam logic [STEP_W-1:0] S_LVL   = 3'd7;

    typedef enum logic [1:0] {
        RD_ZERO = 2'd0,
        RD_IDX1 = 2'd1,
        RD_IDX2 = 2'd2
    } t_rd_sel;

    typedef enum logic [2:0] {
        C_ALWAYS   = 3'd0,
        C_IN_LAST  = 3'd1,
        C_LVL_LE1  = 3'd2,
        C_ROW_DONE = 3'd3,
        C_OUT_FREE = 3'd4
    } t_cond;

    typedef struct packed {
        logic              in_ready;
        t_rd_sel           rd_sel;
        logic              ld_p;
        logic              ld_diff;
        logic              ld_prod;
        logic              wr_en;
        logic              idx_clr;
        logic              idx_inc;
        logic              lvl_dec;
        logic              out_load;
        t_cond             cond;
        logic [STEP_W-1:0] jump_to;
        logic [STEP_W-1:0] seq_to;
    } t_ctl;

    typedef struct packed {
        logic in_last_acc;
        logic lvl_le1;
        logic row_done;
        logic out_free;
    } t_stat;

    function automatic t_ctl ctl_rom(input logic [STEP_W-1:0] step);
        t_ctl c;
        c = '0;
        c.rd_sel  = RD_ZERO;
        c.cond    = C_ALWAYS;
        c.jump_to = S_IDLE;
        c.seq_to  = S_IDLE;
        case (step)
            S_IDLE: begin
                c.in_ready = 1'b1;
                c.cond     = C_IN_LAST;
                c.jump_to  = S_START;
                c.seq_to   = S_IDLE;
            end
            S_START: begin
                c.idx_clr = 1'b1;
                c.cond    = C_LVL_LE1;
                c.jump_to = S_OUT;
                c.seq_to  = S_LD0;
            end
            S_LD0: begin
                c.ld_p    = 1'b1;
                c.rd_sel  = RD_IDX1;
                c.jump_to = S_RDQ;
            end
            S_RDQ: begin
                c.ld_diff = 1'b1;
                c.jump_to = S_MUL;
            end
            S_MUL: begin
                c.ld_prod = 1'b1;
                c.jump_to = S_ADD;
            end
            S_ADD: begin
                c.wr_en   = 1'b1;
                c.idx_inc = 1'b1;
                c.rd_sel  = RD_IDX2;
                c.cond    = C_ROW_DONE;
                c.jump_to = S_LVL;
                c.seq_to  = S_RDQ;
            end
            S_OUT: begin
                c.out_load = 1'b1;
                c.cond     = C_OUT_FREE;
                c.jump_to  = S_IDLE;
                c.seq_to   = S_OUT;
            end
            S_LVL: begin
                c.lvl_dec = 1'b1;
                c.jump_to = S_START;
            end
            default: begin
                c.jump_to = S_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

[rtl/core/bezier_point_eval_unit.sv]
// top level of the bezier point evaluator (de casteljau)
// Evaluates one point of a Bezier curve by de Casteljau's method. Control points
// come in one item per cycle on the s_axis side and are written to a 16-entry
// point store; the item with s_axis_tlast high also carries t (unsigned Q1.16,
// values above 1.0 clamp to 1.0). After that item the block stops taking input
// and a microcoded sequencer walks the store level by level, replacing each
// adjacent pair p, q by p + (q - p) * t rounded to nearest (halves up), until one
// point is left; that point leaves on m_axis with tuser set when points beyond
// the store depth were dropped. The evaluation runs on the one shared
// interpolation step per coordinate, which needs three microcode steps (store
// read, multiply, round and write back) that run one after another with no
// overlap between pairs. Input is held off during reset. A finished result
// waits in the output register while the next curve's points are already
// being loaded.
`include "bezier_point_eval_unit_assert.svh"

module bezier_point_eval_unit import bpe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items: control points
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // point_x[23:0], point_y[47:24], curve_param[64:48], zero
    input  logic        s_axis_tlast,   // last_point
    // result items: evaluated curve point
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // curve_x[23:0], curve_y[47:24]
    output logic        m_axis_tuser    // too_many_points
);

    t_ctl              ctl;
    t_stat             stat;
    logic [STEP_W-1:0] step;

    // input unpacking
    logic [COORD_W-1:0] in_x;
    logic [COORD_W-1:0] in_y;
    logic [T_W-1:0]     in_t;
    logic               in_acc;
    logic               room;
    logic               store;

    // curve bookkeeping
    logic [CNT_W-1:0]  r_cnt;
    logic              r_ovf;
    logic [CNT_W-1:0]  r_lvl;
    logic [T_W-1:0]    r_t;
    logic [ADDR_W-1:0] r_idx;
    logic [CNT_W-1:0]  pair_end;

    // output register
    logic               r_out_valid;
    logic [COORD_W-1:0] r_out_x;
    logic [COORD_W-1:0] r_out_y;
    logic               r_out_flag;
    logic               out_free;
    logic               out_fire;

    logic [COORD_W-1:0] lane_x;
    logic [COORD_W-1:0] lane_y;

    // assertion helpers
    logic               lvl_ok;
    logic               out_done;

    assign in_x  = s_axis_tdata[23:0];
    assign in_y  = s_axis_tdata[47:24];
    assign in_t  = s_axis_tdata[64:48];

    // no item is taken while reset is held
    assign s_axis_tready = ctl.in_ready & i_rst_n;
    assign in_acc        = s_axis_tvalid & s_axis_tready;
    // a point that finds the store full is dropped and only flags the curve
    assign room          = (r_cnt != CNT_W'(MAX_POINTS));
    assign store         = in_acc & room;

    assign out_free = ~r_out_valid | m_axis_tready;
    assign out_fire = ctl.out_load & out_free;

    // last pair of a level is at idx = lvl - 2
    assign pair_end = CNT_W'(r_idx) + CNT_W'(2);

    assign stat.in_last_acc = in_acc & s_axis_tlast;
    assign stat.lvl_le1     = (r_lvl <= CNT_W'(1));
    assign stat.row_done    = (pair_end == r_lvl);
    assign stat.out_free    = out_free;

    bpe_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctl   (ctl),
        .o_step  (step)
    );

    bpe_lane u_lane_x (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_ld_wr   (store),
        .i_ld_addr (r_cnt[ADDR_W-1:0]),
        .i_ld_data (in_x),
        .i_idx     (r_idx),
        .i_t       (r_t),
        .o_rd_data (lane_x)
    );

    bpe_lane u_lane_y (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_ld_wr   (store),
        .i_ld_addr (r_cnt[ADDR_W-1:0]),
        .i_ld_data (in_y),
        .i_idx     (r_idx),
        .i_t       (r_t),
        .o_rd_data (lane_y)
    );

    // point count and drop flag, both cleared when the result is taken over
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (out_fire) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else begin
            if (store) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (in_acc && !room) begin
                r_ovf <= 1'b1;
            end
        end
    end

    // level length, clamped t and pair index of the running evaluation
    always_ff @(posedge i_clk) begin
        if (stat.in_last_acc) begin
            r_lvl <= room ? r_cnt + CNT_W'(1) : r_cnt;
            r_t   <= (in_t > T_ONE) ? T_ONE : in_t;
        end else if (ctl.lvl_dec) begin
            r_lvl <= r_lvl - CNT_W'(1);
        end
        if (ctl.idx_clr) begin
            r_idx <= '0;
        end else if (ctl.idx_inc) begin
            r_idx <= r_idx + ADDR_W'(1);
        end
    end

    // result register: entry 0 of the store holds the point at the end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire) begin
            r_out_x    <= lane_x;
            r_out_y    <= lane_y;
            r_out_flag <= r_ovf;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_y, r_out_x};
    assign m_axis_tuser  = r_out_flag;

    assign lvl_ok   = (r_lvl != '0) && (r_lvl <= CNT_W'(MAX_POINTS));
    assign out_done = (r_cnt == '0) && !r_ovf && m_axis_tvalid;

    `BPE_ASSERT_NOW(a_cnt_bound, 1'b1, r_cnt <= CNT_W'(MAX_POINTS), "count above store depth")
    `BPE_ASSERT_NOW(a_lvl_live, step != S_IDLE, lvl_ok, "level length out of range")
    `BPE_ASSERT_NEXT(a_start, stat.in_last_acc, step == S_START, "evaluation not started")
    `BPE_ASSERT_NEXT(a_clear, out_fire, out_done, "curve state not cleared on result")

endmodule

[rtl/core/bpe_ram.sv]
// generic single-write, single-read ram with registered read data
module bpe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/bpe_lane.sv]
// one coordinate lane: point store plus the shared interpolation datapath
module bpe_lane import bpe_pkg::*; (
    input  logic               i_clk,
    input  t_ctl               i_ctl,
    input  logic               i_ld_wr,
    input  logic [ADDR_W-1:0]  i_ld_addr,
    input  logic [COORD_W-1:0] i_ld_data,
    input  logic [ADDR_W-1:0]  i_idx,
    input  logic [T_W-1:0]     i_t,
    output logic [COORD_W-1:0] o_rd_data
);

    logic [ADDR_W-1:0]         rd_addr;
    logic [COORD_W-1:0]        rd_data;
    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic [COORD_W-1:0]        wr_data;

    logic signed [COORD_W-1:0] r_p;
    logic signed [COORD_W-1:0] r_base;
    logic signed [DIFF_W-1:0]  r_diff;
    logic signed [PROD_W-1:0]  r_prod;

    logic signed [DIFF_W-1:0]  n_diff;
    logic signed [PROD_W-1:0]  n_prod;
    logic [PROD_W-1:0]         rnd;
    logic signed [PROD_W-FRAC_T-1:0] step_sum;
    logic signed [PROD_W-FRAC_T-1:0] interp;

    always_comb begin
        case (i_ctl.rd_sel)
            RD_IDX1: rd_addr = i_idx + ADDR_W'(1);
            RD_IDX2: rd_addr = i_idx + ADDR_W'(2);
            default: rd_addr = '0;
        endcase
    end

    // q - p, then (q - p) * t, then p + round(product / 2^16)
    assign n_diff   = $signed({rd_data[COORD_W-1], rd_data}) - $signed({r_p[COORD_W-1], r_p});
    assign n_prod   = r_diff * $signed({1'b0, i_t});
    assign rnd      = r_prod + T_HALF;
    assign step_sum = $signed(rnd[PROD_W-1:FRAC_T]);
    assign interp   = $signed({{(PROD_W-FRAC_T-COORD_W){r_base[COORD_W-1]}}, r_base}) + step_sum;

    assign wr_en   = i_ld_wr | i_ctl.wr_en;
    assign wr_addr = i_ld_wr ? i_ld_addr : i_idx;
    assign wr_data = i_ld_wr ? i_ld_data : interp[COORD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_p) begin
            r_p <= rd_data;
        end
        if (i_ctl.ld_diff) begin
            r_diff <= n_diff;
            r_base <= r_p;
            r_p    <= rd_data;
        end
        if (i_ctl.ld_prod) begin
            r_prod <= n_prod;
        end
    end

    bpe_ram #(
        .WIDTH (COORD_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_rd_data = rd_data;

endmodule

[rtl/core/bpe_seq.sv]
// microcode sequencer: step counter, control rom and conditional jumps
module bpe_seq import bpe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_stat             i_stat,
    output t_ctl              o_ctl,
    output logic [STEP_W-1:0] o_step
);

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_ctl              ctl;
    logic              take;

    assign ctl = ctl_rom(r_step);

    always_comb begin
        case (ctl.cond)
            C_ALWAYS:   take = 1'b1;
            C_IN_LAST:  take = i_stat.in_last_acc;
            C_LVL_LE1:  take = i_stat.lvl_le1;
            C_ROW_DONE: take = i_stat.row_done;
            C_OUT_FREE: take = i_stat.out_free;
            default:    take = 1'b1;
        endcase
        n_step = take ? ctl.jump_to : ctl.seq_to;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctl  = ctl;
    assign o_step = r_step;

endmodule
